// ===== sv/cwd_pkg.sv =====
// Shared types and constants for the contour warp distance block.
package cwd_pkg;

    localparam int COORD_W  = 16;
    localparam int LEN_W    = 8;
    localparam int COST_W   = 32;
    localparam int ABS_W    = 16;
    localparam int SQ_IN_W  = 42;
    localparam int SQ_OUT_W = 21;
    localparam int DIV_W    = 32;
    localparam int MEAN_W   = 21;
    localparam int STEPS_W  = 9;

    localparam logic [MEAN_W-1:0]  MEAN_MAX  = '1;
    localparam logic [STEPS_W-1:0] STEPS_MAX = '1;

    localparam logic [1:0] FN_LOAD_A = 2'd0;
    localparam logic [1:0] FN_LOAD_B = 2'd1;
    localparam logic [1:0] FN_COMP   = 2'd2;

    localparam logic [1:0] MV_NONE = 2'd0;
    localparam logic [1:0] MV_H    = 2'd1;
    localparam logic [1:0] MV_V    = 2'd2;
    localparam logic [1:0] MV_D    = 2'd3;

    typedef struct packed {
        logic init;
        logic load_a;
        logic load_b;
        logic rd_diag;
        logic mul;
        logic sq_start;
        logic wr_cell;
        logic bt_init;
        logic bt_step;
        logic rd_end;
        logic rd_start;
        logic div_start;
        logic clr_load;
    } t_cmd;

    typedef struct packed {
        logic last_cell;
        logic sq_done;
        logic bt_stop;
        logic div_done;
    } t_sts;

endpackage

// ===== sv/contour_warp_distance_top.sv =====
// Top level of the contour warp distance block: config registers and wiring.
//
// Points load one per cycle while o_busy is low (func 0 first curve, func 1
// second curve; loads past the store depth are dropped). A compute transfer
// (func 2) raises o_busy and runs three phases: a row-by-row fill of the
// len_a x len_b cost table, with each point distance taken from the 21-step
// square-root unit; a backtrace through the single-port move table; and the
// result readout, nearly all of it the 32-step divider.
// The result appears for exactly one cycle with o_done high and cannot be
// stalled; after it both load counts return to zero. len_a/len_b are read
// through saturation into 2..MAX_A / 2..MAX_B. Write config only while idle.
module contour_warp_distance_top #(
    parameter int MAX_A = 128,
    parameter int MAX_B = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_func,
    input  logic signed [15:0] i_coord_x,
    input  logic signed [15:0] i_coord_y,
    // result channel
    output logic        o_done,
    output logic [20:0] o_mean_distance,
    output logic [8:0]  o_path_steps,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [cwd_pkg::LEN_W-1:0] r_len_a, r_len_b;
    cwd_pkg::t_cmd cmd;
    cwd_pkg::t_sts sts;

    // config: len_a at 0x0, len_b at 0x4; paddr[2] picks the register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_a <= cwd_pkg::LEN_W'(2);
            r_len_b <= cwd_pkg::LEN_W'(2);
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) r_len_b <= pwdata[cwd_pkg::LEN_W-1:0];
            else          r_len_a <= pwdata[cwd_pkg::LEN_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'(r_len_b) : 32'(r_len_a);

    cwd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_func  (i_func),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    cwd_dp #(.MAX_A(MAX_A), .MAX_B(MAX_B)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_len_a         (r_len_a),
        .i_len_b         (r_len_b),
        .i_coord_x       (i_coord_x),
        .i_coord_y       (i_coord_y),
        .o_mean_distance (o_mean_distance),
        .o_path_steps    (o_path_steps)
    );
endmodule

// ===== sv/cwd_isqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
module cwd_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [cwd_pkg::SQ_IN_W-1:0]   i_radicand,
    output logic                          o_done,
    output logic [cwd_pkg::SQ_OUT_W-1:0]  o_root
);
    localparam int REM_W = cwd_pkg::SQ_OUT_W + 3;
    localparam int CNT_W = $clog2(cwd_pkg::SQ_OUT_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(cwd_pkg::SQ_OUT_W - 1);

    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic [cwd_pkg::SQ_IN_W-1:0]  r_val, n_val;
    logic [REM_W-1:0]             r_rem, n_rem;
    logic [cwd_pkg::SQ_OUT_W-1:0] r_root, n_root;
    logic [REM_W-1:0]             rem_sh, trial;

    always_comb begin
        rem_sh = {r_rem[REM_W-3:0], r_val[cwd_pkg::SQ_IN_W-1 -: 2]};
        trial  = REM_W'({r_root, 2'b01});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_val  = r_val;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_val  = i_radicand;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_val = {r_val[cwd_pkg::SQ_IN_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem  = rem_sh - trial;
                n_root = {r_root[cwd_pkg::SQ_OUT_W-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh;
                n_root = {r_root[cwd_pkg::SQ_OUT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_val  <= n_val;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ===== sv/cwd_div.sv =====
// Restoring divider, one quotient bit per cycle.
module cwd_div #(
    parameter int DVS_W = 9
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [cwd_pkg::DIV_W-1:0]  i_dividend,
    input  logic [DVS_W-1:0]           i_divisor,
    output logic                       o_done,
    output logic [cwd_pkg::DIV_W-1:0]  o_quotient
);
    localparam int CNT_W = $clog2(cwd_pkg::DIV_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(cwd_pkg::DIV_W - 1);

    logic                      r_busy, n_busy;
    logic                      r_done, n_done;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic [cwd_pkg::DIV_W-1:0] r_q, n_q;
    logic [DVS_W:0]            r_rem, n_rem;
    logic [DVS_W-1:0]          r_dvs, n_dvs;
    logic [DVS_W:0]            sh;

    always_comb begin
        sh     = {r_rem[DVS_W-1:0], r_q[cwd_pkg::DIV_W-1]};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (sh >= {1'b0, r_dvs}) begin
                n_rem = sh - {1'b0, r_dvs};
                n_q   = {r_q[cwd_pkg::DIV_W-2:0], 1'b1};
            end else begin
                n_rem = sh;
                n_q   = {r_q[cwd_pkg::DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

// ===== sv/cwd_dp.sv =====
// Datapath: curve stores, cost and move tables, cell update, backtrace, result.
module cwd_dp #(
    parameter int MAX_A = 128,
    parameter int MAX_B = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cwd_pkg::t_cmd                 i_cmd,
    output cwd_pkg::t_sts                 o_sts,
    input  logic [cwd_pkg::LEN_W-1:0]     i_len_a,
    input  logic [cwd_pkg::LEN_W-1:0]     i_len_b,
    input  logic signed [cwd_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [cwd_pkg::COORD_W-1:0] i_coord_y,
    output logic [cwd_pkg::MEAN_W-1:0]    o_mean_distance,
    output logic [cwd_pkg::STEPS_W-1:0]   o_path_steps
);
    localparam int IW_A = $clog2(MAX_A);
    localparam int IW_B = $clog2(MAX_B);
    localparam int NA_W = IW_A + 1;
    localparam int NB_W = IW_B + 1;
    localparam int CAW  = $clog2(MAX_A + 1);
    localparam int CBW  = $clog2(MAX_B + 1);
    localparam int AW   = $clog2(MAX_A * MAX_B);
    localparam int CW   = $clog2(MAX_A + MAX_B + 1);
    localparam int PW   = 2 * cwd_pkg::COORD_W;
    localparam int SQW  = 2 * cwd_pkg::ABS_W;

    function automatic logic [AW-1:0] f_addr(input logic [IW_A-1:0] row,
                                             input logic [IW_B-1:0] col);
        return AW'(row) * AW'(MAX_B) + AW'(col);
    endfunction

    function automatic logic [cwd_pkg::ABS_W-1:0] f_absdiff(
        input logic [cwd_pkg::COORD_W-1:0] a, input logic [cwd_pkg::COORD_W-1:0] b);
        logic signed [cwd_pkg::COORD_W:0] d;
        d = {a[cwd_pkg::COORD_W-1], a} - {b[cwd_pkg::COORD_W-1], b};
        return d[cwd_pkg::COORD_W] ? cwd_pkg::ABS_W'(-d) : cwd_pkg::ABS_W'(d);
    endfunction

    // storage
    logic [PW-1:0]             mem_a    [MAX_A];
    logic [PW-1:0]             mem_b    [MAX_B];
    logic [cwd_pkg::COST_W-1:0] mem_cost [MAX_A*MAX_B];
    logic [1:0]                mem_mv   [MAX_A*MAX_B];

    logic [CAW-1:0] r_cnt_a;
    logic [CBW-1:0] r_cnt_b;
    logic [NA_W-1:0] r_na;
    logic [NB_W-1:0] r_nb;
    logic [IW_A-1:0] r_i, r_ei, r_si;
    logic [IW_B-1:0] r_j, r_ej, r_sj;
    logic [PW-1:0] r_pa_q, r_pb_q;
    logic [cwd_pkg::COST_W-1:0] r_cost_q, r_up, r_diag, r_left, r_ce;
    logic [1:0] r_mv_q;
    logic [cwd_pkg::ABS_W-1:0] r_ax, r_ay;
    logic [SQW-1:0] r_sqx, r_sqy;
    logic r_left_seen, r_s_nz;
    logic [CW-1:0] r_steps;
    logic [cwd_pkg::MEAN_W-1:0] r_mean;
    logic [cwd_pkg::STEPS_W-1:0] r_pst;

    logic [NA_W-1:0] na_c;
    logic [NB_W-1:0] nb_c;
    logic [AW-1:0] rd_addr, ij_addr;
    logic [IW_A-1:0] im1, ni;
    logic [IW_B-1:0] jm1, nj;
    logic last_j, last_i, left_now, stop;
    logic [cwd_pkg::COST_W-1:0] best, cell_cost;
    logic [1:0] best_mv;
    logic [cwd_pkg::SQ_IN_W-1:0] radicand;
    logic sq_done, div_done;
    logic [cwd_pkg::SQ_OUT_W-1:0] root;
    logic [cwd_pkg::COST_W:0] diff;
    logic [cwd_pkg::DIV_W-1:0] dividend, quot;

    // length saturation
    always_comb begin
        if (32'(i_len_a) < 32'd2)        na_c = NA_W'(2);
        else if (32'(i_len_a) > MAX_A)   na_c = NA_W'(MAX_A);
        else                             na_c = NA_W'(i_len_a);
        if (32'(i_len_b) < 32'd2)        nb_c = NB_W'(2);
        else if (32'(i_len_b) > MAX_B)   nb_c = NB_W'(MAX_B);
        else                             nb_c = NB_W'(i_len_b);
    end

    assign im1     = (r_i == '0) ? '0 : r_i - 1'b1;
    assign jm1     = (r_j == '0) ? '0 : r_j - 1'b1;
    assign ij_addr = f_addr(r_i, r_j);
    assign last_j  = (NB_W'(r_j) == r_nb - 1'b1);
    assign last_i  = (NA_W'(r_i) == r_na - 1'b1);

    always_comb begin
        if (i_cmd.rd_diag)       rd_addr = f_addr(im1, jm1);
        else if (i_cmd.rd_end)   rd_addr = f_addr(r_ei, r_ej);
        else if (i_cmd.rd_start) rd_addr = f_addr(r_si, r_sj);
        else                     rd_addr = f_addr(im1, r_j);
    end

    // cell update: ties keep horizontal, then vertical
    always_comb begin
        best    = r_left;
        best_mv = cwd_pkg::MV_H;
        if (r_i == '0 && r_j == '0) begin
            best    = '0;
            best_mv = cwd_pkg::MV_NONE;
        end else if (r_i == '0) begin
            best    = r_left;
            best_mv = cwd_pkg::MV_H;
        end else if (r_j == '0) begin
            best    = r_up;
            best_mv = cwd_pkg::MV_V;
        end else begin
            if (r_up < best) begin
                best    = r_up;
                best_mv = cwd_pkg::MV_V;
            end
            if (r_diag < best) begin
                best    = r_diag;
                best_mv = cwd_pkg::MV_D;
            end
        end
        cell_cost = best + cwd_pkg::COST_W'(root);
    end

    // one backtrace step
    always_comb begin
        ni = (r_mv_q == cwd_pkg::MV_H) ? r_i : r_i - 1'b1;
        nj = (r_mv_q == cwd_pkg::MV_V) ? r_j : r_j - 1'b1;
        left_now = !r_left_seen && (NB_W'(nj) < r_nb - 1'b1)
                   && (NA_W'(ni) < r_na - 1'b1);
        stop = (ni == '0) || (nj == '0);
    end

    assign radicand = cwd_pkg::SQ_IN_W'({(SQW+1)'(r_sqx) + (SQW+1)'(r_sqy), 8'h00});

    assign diff = {1'b0, r_ce} - (r_s_nz ? {1'b0, r_cost_q} : '0);
    assign dividend = diff[cwd_pkg::COST_W] ? '0 : diff[cwd_pkg::COST_W-1:0];

    cwd_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sq_start),
        .i_radicand (radicand),
        .o_done     (sq_done),
        .o_root     (root)
    );

    cwd_div #(.DVS_W(CW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (r_steps),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a && 32'(r_cnt_a) < MAX_A)
            mem_a[r_cnt_a[IW_A-1:0]] <= {i_coord_y, i_coord_x};
        if (i_cmd.load_b && 32'(r_cnt_b) < MAX_B)
            mem_b[r_cnt_b[IW_B-1:0]] <= {i_coord_y, i_coord_x};
        r_pa_q <= mem_a[r_i];
        r_pb_q <= mem_b[r_j];
        if (i_cmd.wr_cell) begin
            mem_cost[ij_addr] <= cell_cost;
            mem_mv[ij_addr]   <= best_mv;
        end
        r_cost_q <= mem_cost[rd_addr];
        r_mv_q   <= mem_mv[ij_addr];
    end

    // load counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
        end else if (i_cmd.clr_load) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
        end else begin
            if (i_cmd.load_a && 32'(r_cnt_a) < MAX_A) r_cnt_a <= r_cnt_a + 1'b1;
            if (i_cmd.load_b && 32'(r_cnt_b) < MAX_B) r_cnt_b <= r_cnt_b + 1'b1;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_na <= na_c;
            r_nb <= nb_c;
            r_i  <= '0;
            r_j  <= '0;
        end
        if (i_cmd.rd_diag) begin
            r_up <= r_cost_q;
            r_ax <= f_absdiff(r_pa_q[cwd_pkg::COORD_W-1:0], r_pb_q[cwd_pkg::COORD_W-1:0]);
            r_ay <= f_absdiff(r_pa_q[PW-1:cwd_pkg::COORD_W], r_pb_q[PW-1:cwd_pkg::COORD_W]);
        end
        if (i_cmd.mul) begin
            r_diag <= r_cost_q;
            r_sqx  <= r_ax * r_ax;
            r_sqy  <= r_ay * r_ay;
        end
        if (i_cmd.wr_cell) begin
            r_left <= cell_cost;
            if (last_j) begin
                r_j <= '0;
                if (!last_i) r_i <= r_i + 1'b1;
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
        if (i_cmd.bt_init) begin
            r_i         <= IW_A'(r_na - 1'b1);
            r_j         <= IW_B'(r_nb - 1'b1);
            r_left_seen <= 1'b0;
            r_steps     <= CW'(1);
            r_ei        <= '0;
            r_ej        <= '0;
        end
        if (i_cmd.bt_step) begin
            r_i <= ni;
            r_j <= nj;
            if (left_now) begin
                r_left_seen <= 1'b1;
                r_ei <= (r_mv_q == cwd_pkg::MV_H) ? ni : ni + 1'b1;
                r_ej <= (r_mv_q == cwd_pkg::MV_V) ? nj : nj + 1'b1;
            end
            if (r_left_seen || left_now) r_steps <= r_steps + 1'b1;
            if (stop) begin
                if (ni == '0 && nj != '0) begin
                    r_si <= '0;
                    r_sj <= nj - 1'b1;
                end else if (ni != '0) begin
                    r_si <= ni - 1'b1;
                    r_sj <= '0;
                end else begin
                    r_si <= '0;
                    r_sj <= '0;
                end
                // start cell at the origin: no subtraction
                r_s_nz <= !(ni == '0 && nj == '0) && !(nj == '0 && ni == IW_A'(1))
                          && !(ni == '0 && nj == IW_B'(1));
            end
        end
        if (i_cmd.rd_start) r_ce <= r_cost_q;
        if (div_done) begin
            r_mean <= (quot > cwd_pkg::DIV_W'(cwd_pkg::MEAN_MAX)) ? cwd_pkg::MEAN_MAX
                                                                  : cwd_pkg::MEAN_W'(quot);
            r_pst  <= (32'(r_steps) > 32'(cwd_pkg::STEPS_MAX)) ? cwd_pkg::STEPS_MAX
                                                               : cwd_pkg::STEPS_W'(r_steps);
        end
    end

    assign o_sts.last_cell = last_i && last_j;
    assign o_sts.sq_done   = sq_done;
    assign o_sts.bt_stop   = stop;
    assign o_sts.div_done  = div_done;

    assign o_mean_distance = r_mean;
    assign o_path_steps    = r_pst;
endmodule

// ===== sv/cwd_ctrl.sv =====
// Sequencer for point loads, table fill, backtrace and the final division.
module cwd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_func,
    input  cwd_pkg::t_sts i_sts,
    output cwd_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_done
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_F_RD  = 4'd1;
    localparam logic [3:0] S_F_RD2 = 4'd2;
    localparam logic [3:0] S_F_MUL = 4'd3;
    localparam logic [3:0] S_F_SUM = 4'd4;
    localparam logic [3:0] S_F_SQ  = 4'd5;
    localparam logic [3:0] S_F_WR  = 4'd6;
    localparam logic [3:0] S_B_INI = 4'd7;
    localparam logic [3:0] S_B_RD  = 4'd8;
    localparam logic [3:0] S_B_ST  = 4'd9;
    localparam logic [3:0] S_E_RD1 = 4'd10;
    localparam logic [3:0] S_E_RD2 = 4'd11;
    localparam logic [3:0] S_E_SUB = 4'd12;
    localparam logic [3:0] S_E_DIV = 4'd13;
    localparam logic [3:0] S_E_OUT = 4'd14;

    logic [3:0] r_state, n_state;
    logic       acc;

    assign acc = i_start && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load_a = acc && (i_func == cwd_pkg::FN_LOAD_A);
                o_cmd.load_b = acc && (i_func == cwd_pkg::FN_LOAD_B);
                if (acc && i_func == cwd_pkg::FN_COMP) begin
                    o_cmd.init = 1'b1;
                    n_state    = S_F_RD;
                end
            end
            S_F_RD:  n_state = S_F_RD2;
            S_F_RD2: begin
                o_cmd.rd_diag = 1'b1;
                n_state       = S_F_MUL;
            end
            S_F_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_F_SUM;
            end
            S_F_SUM: begin
                o_cmd.sq_start = 1'b1;
                n_state        = S_F_SQ;
            end
            S_F_SQ:  if (i_sts.sq_done) n_state = S_F_WR;
            S_F_WR: begin
                o_cmd.wr_cell = 1'b1;
                n_state       = i_sts.last_cell ? S_B_INI : S_F_RD;
            end
            S_B_INI: begin
                o_cmd.bt_init = 1'b1;
                n_state       = S_B_RD;
            end
            S_B_RD:  n_state = S_B_ST;
            S_B_ST: begin
                o_cmd.bt_step = 1'b1;
                n_state       = i_sts.bt_stop ? S_E_RD1 : S_B_RD;
            end
            S_E_RD1: begin
                o_cmd.rd_end = 1'b1;
                n_state      = S_E_RD2;
            end
            S_E_RD2: begin
                o_cmd.rd_start = 1'b1;
                n_state        = S_E_SUB;
            end
            S_E_SUB: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_E_DIV;
            end
            S_E_DIV: if (i_sts.div_done) n_state = S_E_OUT;
            S_E_OUT: begin
                o_cmd.clr_load = 1'b1;
                n_state        = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_E_OUT);

    a_comp_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_func == cwd_pkg::FN_COMP) |=> o_busy)
        else $error("compute transfer did not start the sequence");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_busy)
        else $error("block still busy after result");
    a_wr_after_sq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_F_WR) |-> $past(i_sts.sq_done))
        else $error("cell written before distance ready");
endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the contour warp distance block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         MAX_PTS   = 128;
    localparam logic [1:0] FN_NOP    = 2'd3;   // unused code, block ignores it
    localparam logic [2:0] ADDR_LEN_A = 3'd0;
    localparam logic [2:0] ADDR_LEN_B = 3'd4;
    localparam int         STALL_LIMIT = 2000000; // several 128x128 computes
    localparam int         SETTLE      = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_func;
    logic signed [15:0] i_coord_x;
    logic signed [15:0] i_coord_y;
    logic        o_done;
    logic [20:0] o_mean_distance;
    logic [8:0]  o_path_steps;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    contour_warp_distance_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(i_start), .o_busy(o_busy), .i_func(i_func),
        .i_coord_x(i_coord_x), .i_coord_y(i_coord_y),
        .o_done(o_done), .o_mean_distance(o_mean_distance),
        .o_path_steps(o_path_steps),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // ---------------------------------------------------------------
    // Predictor state: point stores, write counts, lengths, tables
    // ---------------------------------------------------------------
    typedef struct packed {
        logic [cwd_pkg::MEAN_W-1:0]  mean;
        logic [cwd_pkg::STEPS_W-1:0] steps;
    } warp_result_t;

    logic [31:0]  pts_a [MAX_PTS];
    logic [31:0]  pts_b [MAX_PTS];
    int unsigned  wr_a, wr_b;
    logic [7:0]   cfg_len_a, cfg_len_b;
    logic [31:0]  cost_tab [MAX_PTS][MAX_PTS];
    logic [1:0]   move_tab [MAX_PTS][MAX_PTS];

    warp_result_t expected_warp [$];
    int           errors;
    int           n_items;
    int           idle_cycles;
    int           burst_left;

    // ---------------------------------------------------------------
    // Clock and watchdog
    // ---------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Counts cycles where no transfer happens on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Prediction helpers
    // ---------------------------------------------------------------
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    // Euclidean distance in 1/16 units.
    function automatic logic [31:0] pt_dist(logic [31:0] pa, logic [31:0] pb);
        longint dx, dy;
        longint unsigned sq;
        dx = longint'($signed(pa[15:0])) - longint'($signed(pb[15:0]));
        dy = longint'($signed(pa[31:16])) - longint'($signed(pb[31:16]));
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        sq = (dx * dx + dy * dy) * 256;
        return 32'(int_sqrt(sq));
    endfunction

    function automatic int sat_len(logic [7:0] v);
        if (v < 2) return 2;
        if (v > MAX_PTS) return MAX_PTS;
        return int'(v);
    endfunction

    // Fills the warp tables, backtraces, trims the end run and divides.
    function automatic warp_result_t predict_warp();
        int na, nb, i, j, ei, ej, si, sj, cnt;
        logic [31:0] best;
        logic [1:0] mv;
        bit left_end;
        longint c;
        longint unsigned mean;
        warp_result_t r;
        na = sat_len(cfg_len_a);
        nb = sat_len(cfg_len_b);
        cost_tab[0][0] = pt_dist(pts_a[0], pts_b[0]);
        for (j = 1; j < nb; j++) begin
            cost_tab[0][j] = cost_tab[0][j-1] + pt_dist(pts_a[0], pts_b[j]);
            move_tab[0][j] = cwd_pkg::MV_H;
        end
        for (i = 1; i < na; i++) begin
            cost_tab[i][0] = cost_tab[i-1][0] + pt_dist(pts_a[i], pts_b[0]);
            move_tab[i][0] = cwd_pkg::MV_V;
        end
        for (i = 1; i < na; i++) begin
            for (j = 1; j < nb; j++) begin
                best = cost_tab[i][j-1];
                mv = cwd_pkg::MV_H;
                if (cost_tab[i-1][j] < best) begin
                    best = cost_tab[i-1][j];
                    mv = cwd_pkg::MV_V;
                end
                if (cost_tab[i-1][j-1] < best) begin
                    best = cost_tab[i-1][j-1];
                    mv = cwd_pkg::MV_D;
                end
                cost_tab[i][j] = best + pt_dist(pts_a[i], pts_b[j]);
                move_tab[i][j] = mv;
            end
        end
        ei = 0; ej = 0; si = 0; sj = 0; cnt = 1;
        left_end = 1'b0;
        i = na - 1;
        j = nb - 1;
        forever begin
            mv = move_tab[i][j];
            if (mv == cwd_pkg::MV_H) j--;
            else if (mv == cwd_pkg::MV_V) i--;
            else begin
                i--;
                j--;
            end
            // first step off the last row and column marks the trimmed end
            if (!left_end && j < nb - 1 && i < na - 1) begin
                left_end = 1'b1;
                ei = (mv == cwd_pkg::MV_H) ? i : i + 1;
                ej = (mv == cwd_pkg::MV_V) ? j : j + 1;
            end
            if (left_end) cnt++;
            if (i == 0 || j == 0) begin
                if (i == 0 && j != 0) begin
                    si = 0;
                    sj = j - 1;
                end else if (i != 0) begin
                    si = i - 1;
                    sj = 0;
                end
                break;
            end
        end
        c = longint'(cost_tab[ei][ej]);
        if (si + sj != 0) c = c - longint'(cost_tab[si][sj]);
        if (c < 0) c = 0;
        mean = longint'(c) / cnt;
        r.mean = (mean > 2097151) ? cwd_pkg::MEAN_MAX : cwd_pkg::MEAN_W'(mean);
        r.steps = (cnt > 511) ? cwd_pkg::STEPS_MAX : cwd_pkg::STEPS_W'(cnt);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Result checker: the block cannot be held off, check every strobe
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        warp_result_t exp_r;
        if (i_rst_n && o_done) begin
            if (expected_warp.size() == 0) begin
                $display("%0t: unexpected result mean %0d steps %0d",
                         $realtime, o_mean_distance, o_path_steps);
                errors++;
            end else begin
                exp_r = expected_warp.pop_front();
                if (o_mean_distance !== exp_r.mean) begin
                    $display("%0t: mean_distance expected %0d actual %0d",
                             $realtime, exp_r.mean, o_mean_distance);
                    errors++;
                end
                if (o_path_steps !== exp_r.steps) begin
                    $display("%0t: path_steps expected %0d actual %0d",
                             $realtime, exp_r.steps, o_path_steps);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Command sender: bursts with random gaps
    // ---------------------------------------------------------------
    task automatic send_cmd(logic [1:0] fn, logic [15:0] x, logic [15:0] y);
        int gap;
        i_start   <= 1'b1;
        i_func    <= fn;
        i_coord_x <= x;
        i_coord_y <= y;
        do @(posedge i_clk); while (o_busy);
        // transfer taken at this edge
        case (fn)
            cwd_pkg::FN_LOAD_A: begin
                if (wr_a < MAX_PTS) begin
                    pts_a[wr_a] = {y, x};
                    wr_a++;
                end
            end
            cwd_pkg::FN_LOAD_B: begin
                if (wr_b < MAX_PTS) begin
                    pts_b[wr_b] = {y, x};
                    wr_b++;
                end
            end
            cwd_pkg::FN_COMP: begin
                expected_warp.push_back(predict_warp());
                wr_a = 0;
                wr_b = 0;
            end
            default: ;
        endcase
        if (fn != FN_NOP) n_items++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(0, 8);
            if (gap > 0) begin
                i_start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Drops start and waits until every result is in and the block is idle.
    task automatic wait_idle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (expected_warp.size() != 0 || o_busy) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_LEN_A) cfg_len_a = data[7:0];
        else cfg_len_b = data[7:0];
    endtask

    task automatic set_lengths(logic [7:0] la, logic [7:0] lb);
        wait_idle();
        apb_write(ADDR_LEN_A, {24'd0, la});
        apb_write(ADDR_LEN_B, {24'd0, lb});
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_coord(bit wide);
        if (wide) return 16'($urandom);
        return 16'($urandom_range(0, 64) - 32);
    endfunction

    // Loads na/nb points in a random interleave, then computes.
    task automatic run_contours(int na, int nb, bit wide);
        int la, lb;
        la = 0;
        lb = 0;
        while (la < na || lb < nb) begin
            if (lb >= nb || (la < na && $urandom_range(0, 1))) begin
                send_cmd(cwd_pkg::FN_LOAD_A, rand_coord(wide), rand_coord(wide));
                la++;
            end else begin
                send_cmd(cwd_pkg::FN_LOAD_B, rand_coord(wide), rand_coord(wide));
                lb++;
            end
            if ($urandom_range(0, 30) == 0)
                send_cmd(FN_NOP, 16'($urandom), 16'($urandom));
        end
        send_cmd(cwd_pkg::FN_COMP, 16'($urandom), 16'($urandom));
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset lengths (2 x 2) with extreme coordinates, no config write yet.
    task automatic test_reset_lengths();
        send_cmd(cwd_pkg::FN_LOAD_A, 16'h7FFF, 16'h7FFF);
        send_cmd(cwd_pkg::FN_LOAD_A, 16'h8000, 16'h8000);
        send_cmd(cwd_pkg::FN_LOAD_B, 16'h8000, 16'h7FFF);
        send_cmd(cwd_pkg::FN_LOAD_B, 16'h7FFF, 16'h8000);
        send_cmd(FN_NOP, 16'hFFFF, 16'hFFFF);
        send_cmd(cwd_pkg::FN_COMP, 16'h0000, 16'h0000);
    endtask

    // Identical points: every cell ties, path runs along the edges.
    task automatic test_all_ties();
        set_lengths(8'd3, 8'd3);
        repeat (3) send_cmd(cwd_pkg::FN_LOAD_A, 16'h0010, 16'hFFF0);
        repeat (3) send_cmd(cwd_pkg::FN_LOAD_B, 16'h0010, 16'hFFF0);
        send_cmd(cwd_pkg::FN_COMP, 16'h0, 16'h0);
    endtask

    // Lengths below two saturate up; second curve longer than first.
    task automatic test_length_saturation();
        set_lengths(8'd0, 8'd1);
        run_contours(2, 2, 1'b1);
        set_lengths(8'd3, 8'd6);
        run_contours(3, 6, 1'b0);
    endtask

    // More loads than the store holds: the overflow is dropped.
    task automatic test_curve_full();
        set_lengths(8'd128, 8'd2);
        run_contours(MAX_PTS + 3, 2, 1'b0);
    endtask

    // One full-size compute, lengths at and above the maximum.
    task automatic test_max_size();
        set_lengths(8'd128, 8'd255);
        run_contours(MAX_PTS, MAX_PTS, 1'b1);
    endtask

    // Random small contours, mostly len_a >= len_b, random coordinate spread.
    task automatic test_random_contours();
        int na, nb, t;
        while (n_items < 850) begin
            na = $urandom_range(2, 9);
            nb = $urandom_range(2, 9);
            if ($urandom_range(0, 4) != 0 && nb > na) begin
                t = na;
                na = nb;
                nb = t;
            end
            set_lengths(8'(na), 8'(nb));
            run_contours(na, nb, $urandom_range(0, 1));
        end
    endtask

    initial begin
        i_rst_n   = 1'b0;
        i_start   = 1'b0;
        i_func    = cwd_pkg::FN_LOAD_A;
        i_coord_x = '0;
        i_coord_y = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = ADDR_LEN_A;
        pwdata    = '0;
        errors    = 0;
        n_items   = 0;
        wr_a      = 0;
        wr_b      = 0;
        cfg_len_a = 8'd2;
        cfg_len_b = 8'd2;
        burst_left = 0;
        idle_cycles = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_lengths();
        test_all_ties();
        test_length_saturation();
        test_curve_full();
        test_max_size();
        test_random_contours();

        wait_idle();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
